>>> sv/bmp_distinct_color_collector_top_macros.svh
// Assertion macros for the BMP distinct color collector.
// Used by the controller; expects clk and rst_n in scope.
`ifndef BMP_DISTINCT_COLOR_COLLECTOR_TOP_MACROS_SVH
`define BMP_DISTINCT_COLOR_COLLECTOR_TOP_MACROS_SVH
`ifndef SYNTH
`define BDC_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("bdc assertion failed");
`define BDC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bdc assertion failed");
`define BDC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bdc assertion failed");
`else
`define BDC_ASSERT(lbl, cond)
`define BDC_ASSERT_IMP(lbl, ante, cons)
`define BDC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> sv/bdc_pkg.sv
// Shared types and constants of the BMP distinct color collector.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bdc_pkg;
    localparam int DEF_PALETTE_DEPTH = 256;
    localparam int DEF_MAX_WIDTH     = 8192;
    localparam int HEADER_SIZE       = 54;
    localparam logic [8:0] COLOR_CAP_RESET = 9'd256;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BAD_SIG = 3'd1;
    localparam logic [2:0] ST_NOT_24  = 3'd2;
    localparam logic [2:0] ST_SHORT   = 3'd3;
    localparam logic [2:0] ST_GEOM    = 3'd4;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SKIP,
        PH_PIXELS,
        PH_DONE,
        PH_ERROR
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_EMIT_C,
        S_SUM
    } state_t;

    typedef struct packed {
        logic take;
        logic rd;
        logic inc;
        logic commit;
        logic summary;
    } cmd_t;

    typedef struct packed {
        logic pix_done;
        logic idx_end;
        logic match;
        logic out_free;
    } sts_t;
endpackage
`default_nettype wire

>>> sv/bdc_ctrl.sv
// Controller: byte acceptance, palette scan sequencing and result emission.
// Depends on bdc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "bmp_distinct_color_collector_top_macros.svh"
module bdc_ctrl (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic         s_tlast,
    input  wire bdc_pkg::sts_t sts,
    output bdc_pkg::cmd_t     cmd
);
    import bdc_pkg::*;

    state_t state_reg, state_next;
    logic   last_reg, last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.take  = 1'b1;
                    last_next = s_tlast;
                    if (sts.pix_done)
                        state_next = S_RD;
                    else if (s_tlast)
                        state_next = S_SUM;
                end
            end
            S_RD:
            begin
                if (sts.idx_end)
                    state_next = S_EMIT_C;
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (sts.match)
                    state_next = last_reg ? S_SUM : S_IDLE;
                else
                begin
                    cmd.inc    = 1'b1;
                    state_next = S_RD;
                end
            end
            S_EMIT_C:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = last_reg ? S_SUM : S_IDLE;
                end
            end
            S_SUM:
            begin
                if (sts.out_free)
                begin
                    cmd.summary = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // compare only ever follows a palette read
    `BDC_ASSERT_IMP(a_cmp_after_rd, state_reg == S_CMP, $past(state_reg) == S_RD)
    // a new color is only emitted once the scan reached the fill count
    `BDC_ASSERT_IMP(a_emit_at_end, state_reg == S_EMIT_C, sts.idx_end)
    // a final byte that completes nothing goes straight to the summary
    `BDC_ASSERT_NEXT(a_last_to_sum, cmd.take && s_tlast && !sts.pix_done, state_reg == S_SUM)
endmodule
`default_nettype wire

>>> sv/bdc_datapath.sv
// Datapath: header parsing, pixel assembly, palette memory and output register.
// Depends on bdc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bdc_datapath #(
    parameter int PALETTE_DEPTH = bdc_pkg::DEF_PALETTE_DEPTH,
    parameter int MAX_WIDTH     = bdc_pkg::DEF_MAX_WIDTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          color_cap_we,
    input  wire logic [8:0]    color_cap_wdata,
    input  wire logic [7:0]    s_tdata,
    input  wire bdc_pkg::cmd_t cmd,
    output bdc_pkg::sts_t      sts,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [47:0]        m_tdata,
    output logic               m_tlast
);
    import bdc_pkg::*;

    localparam int PD  = (PALETTE_DEPTH < 256) ? PALETTE_DEPTH : 256;
    localparam int AW  = (PD > 1) ? $clog2(PD) : 1;
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int RBW = $clog2(3 * MAX_WIDTH + 4);
    localparam logic [8:0] PD9 = 9'(PD);

    logic [8:0]     color_cap_reg;
    logic [31:0]    pos_reg, pos_next;
    logic [31:0]    offset_reg, offset_next;
    logic [31:0]    width_reg, width_next;
    logic [31:0]    height_reg, height_next;
    logic [15:0]    bpp_reg, bpp_next;
    logic [RBW-1:0] col_reg, col_next;
    logic [1:0]     k_reg, k_next;
    logic [31:0]    row_reg, row_next;
    logic [15:0]    partial_reg, partial_next;
    logic [23:0]    rgb_reg, rgb_next;
    logic [8:0]     found_reg, found_next;
    logic [2:0]     err_reg, err_next;
    phase_t         phase_reg, phase_next;
    logic [8:0]     idx_reg;
    logic [23:0]    pal [PD];
    logic [23:0]    rd_data_reg;
    logic           out_valid_reg;
    logic [47:0]    out_data_reg;
    logic           out_last_reg;

    logic [8:0]     lim;
    logic [WW-1:0]  w_lo;
    logic [RBW-1:0] w3, w3p3, rb, col_inc;
    logic [31:0]    hmag, row_inc;
    logic           out_free;
    logic           lim_hit;
    logic [2:0]     st_sum;
    phase_t         enter_ph;

    assign lim     = (color_cap_reg > PD9) ? PD9 : color_cap_reg;
    assign w_lo    = width_reg[WW-1:0];
    assign w3      = RBW'(w_lo) + (RBW'(w_lo) << 1);
    assign w3p3    = w3 + RBW'(3);
    assign rb      = {w3p3[RBW-1:2], 2'b00};
    assign hmag    = height_reg[31] ? (~height_reg + 32'd1) : height_reg;
    assign col_inc = col_reg + RBW'(1);
    assign row_inc = row_reg + 32'd1;
    assign lim_hit = found_reg >= lim;
    assign out_free = !out_valid_reg || m_tready;
    assign enter_ph = (rb == '0 || hmag == 32'd0 || lim_hit) ? PH_DONE : PH_PIXELS;
    assign st_sum  = (phase_reg == PH_HEADER) ? ST_SHORT : err_reg;

    assign sts.pix_done = (phase_reg == PH_PIXELS) && !lim_hit && (col_reg < w3)
                          && (k_reg == 2'd2);
    assign sts.idx_end  = (idx_reg == found_reg);
    assign sts.match    = (rd_data_reg == rgb_reg);
    assign sts.out_free = out_free;

    always_comb
    begin
        pos_next     = pos_reg;
        offset_next  = offset_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        bpp_next     = bpp_reg;
        col_next     = col_reg;
        k_next       = k_reg;
        row_next     = row_reg;
        partial_next = partial_reg;
        rgb_next     = rgb_reg;
        found_next   = found_reg;
        err_next     = err_reg;
        phase_next   = phase_reg;
        if (cmd.take)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    case (pos_reg[5:0])
                        6'd0:  if (s_tdata != 8'h42) err_next = ST_BAD_SIG;
                        6'd1:  if (s_tdata != 8'h4D) err_next = ST_BAD_SIG;
                        6'd10: offset_next[7:0]   = s_tdata;
                        6'd11: offset_next[15:8]  = s_tdata;
                        6'd12: offset_next[23:16] = s_tdata;
                        6'd13: offset_next[31:24] = s_tdata;
                        6'd18: width_next[7:0]    = s_tdata;
                        6'd19: width_next[15:8]   = s_tdata;
                        6'd20: width_next[23:16]  = s_tdata;
                        6'd21: width_next[31:24]  = s_tdata;
                        6'd22: height_next[7:0]   = s_tdata;
                        6'd23: height_next[15:8]  = s_tdata;
                        6'd24: height_next[23:16] = s_tdata;
                        6'd25: height_next[31:24] = s_tdata;
                        6'd28: bpp_next[7:0]      = s_tdata;
                        6'd29: bpp_next[15:8]     = s_tdata;
                        6'(HEADER_SIZE - 1):
                        begin
                            if (err_reg != ST_OK)
                                phase_next = PH_ERROR;
                            else if (bpp_reg != 16'd24)
                            begin
                                err_next   = ST_NOT_24;
                                phase_next = PH_ERROR;
                            end
                            else if (offset_reg < 32'(HEADER_SIZE) || width_reg[31]
                                     || width_reg > 32'(MAX_WIDTH))
                            begin
                                err_next   = ST_GEOM;
                                phase_next = PH_ERROR;
                            end
                            else if (offset_reg > 32'(HEADER_SIZE))
                                phase_next = PH_SKIP;
                            else
                                phase_next = enter_ph;
                        end
                        default: ;
                    endcase
                end
                PH_PIXELS:
                begin
                    if (lim_hit)
                        phase_next = PH_DONE;
                    else
                    begin
                        if (col_reg < w3)
                        begin
                            case (k_reg)
                                2'd0:    partial_next[7:0]  = s_tdata;
                                2'd1:    partial_next[15:8] = s_tdata;
                                default: rgb_next = {s_tdata, partial_reg};
                            endcase
                            k_next = (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                        end
                        col_next = col_inc;
                        if (col_inc >= rb)
                        begin
                            col_next = '0;
                            k_next   = 2'd0;
                            row_next = row_inc;
                            if (row_inc >= hmag)
                                phase_next = PH_DONE;
                        end
                    end
                end
                default: ;
            endcase
            if (pos_reg != 32'hFFFF_FFFF)
                pos_next = pos_reg + 32'd1;
            if (phase_reg == PH_SKIP && pos_next >= offset_reg)
                phase_next = enter_ph;
        end
        if (cmd.commit)
        begin
            found_next = found_reg + 9'd1;
            if (found_reg + 9'd1 >= lim)
                phase_next = PH_DONE;
        end
        if (cmd.summary)
        begin
            pos_next     = '0;
            offset_next  = '0;
            width_next   = '0;
            height_next  = '0;
            bpp_next     = '0;
            col_next     = '0;
            k_next       = '0;
            row_next     = '0;
            partial_next = '0;
            found_next   = '0;
            err_next     = ST_OK;
            phase_next   = PH_HEADER;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_cap_reg  <= COLOR_CAP_RESET;
            pos_reg        <= '0;
            offset_reg     <= '0;
            width_reg      <= '0;
            height_reg     <= '0;
            bpp_reg        <= '0;
            col_reg        <= '0;
            k_reg          <= '0;
            row_reg        <= '0;
            partial_reg    <= '0;
            found_reg      <= '0;
            err_reg        <= ST_OK;
            phase_reg      <= PH_HEADER;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (color_cap_we)
                color_cap_reg <= color_cap_wdata;
            pos_reg     <= pos_next;
            offset_reg  <= offset_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            bpp_reg     <= bpp_next;
            col_reg     <= col_next;
            k_reg       <= k_next;
            row_reg     <= row_next;
            partial_reg <= partial_next;
            found_reg   <= found_next;
            err_reg     <= err_next;
            phase_reg   <= phase_next;
            if (cmd.take)
                idx_reg <= '0;
            else if (cmd.inc)
                idx_reg <= idx_reg + 9'd1;
            if (cmd.commit || cmd.summary)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rgb_reg <= rgb_next;
        if (cmd.commit)
        begin
            out_last_reg <= 1'b0;
            out_data_reg <= {4'd0, 3'd0, 9'd0, rgb_reg[7:0], rgb_reg[15:8], rgb_reg[23:16],
                             found_reg[7:0]};
        end
        else if (cmd.summary)
        begin
            out_last_reg <= 1'b1;
            out_data_reg <= {4'd0, st_sum, (st_sum == ST_OK) ? found_reg : 9'd0, 32'd0};
        end
    end

    // palette memory, one port each way
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
            pal[found_reg[AW-1:0]] <= rgb_reg;
        if (cmd.rd)
            rd_data_reg <= pal[idx_reg[AW-1:0]];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
endmodule
`default_nettype wire

>>> sv/bmp_distinct_color_collector_top.sv
// Top level of the BMP distinct color collector.
// Depends on bdc_pkg, bdc_ctrl and bdc_datapath.
//
// Input stream: one file byte per transfer on s_tdata, s_tlast on the final
// byte. Output stream: a new-color record (m_tlast low) or an end-of-file
// summary (m_tlast high) per transfer, held in an output register.
// The color limit is written through color_cap_we / color_cap_wdata.
// Header, skip and padding bytes, and the first two bytes of each pixel,
// are taken with no palette scan. A byte that completes a pixel scans the
// palette through its single read port, a read and then a compare per
// stored color, until a match or the filled slots end (plus output wait).
// A final byte that completes nothing goes straight on to the summary.
// Reset clears all file state and sets the color limit to 256; the palette
// needs no clearing since only filled slots are read.
// When the receiver stalls, a pending result holds; bytes are still taken
// until the next result is due, which then waits until it can be loaded.
`timescale 1ns / 1ps
`default_nettype none
module bmp_distinct_color_collector_top #(
    parameter int PALETTE_DEPTH = bdc_pkg::DEF_PALETTE_DEPTH,
    parameter int MAX_WIDTH     = bdc_pkg::DEF_MAX_WIDTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        color_cap_we,
    input  wire logic [8:0]  color_cap_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // file_byte
    input  wire logic        s_tlast,   // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // color_index, red, green, blue, color_count, status
    output logic             m_tlast    // kind
);
    import bdc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    bdc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .sts      (sts),
        .cmd      (cmd)
    );

    bdc_datapath #(
        .PALETTE_DEPTH (PALETTE_DEPTH),
        .MAX_WIDTH     (MAX_WIDTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .color_cap_we    (color_cap_we),
        .color_cap_wdata (color_cap_wdata),
        .s_tdata         (s_tdata),
        .cmd             (cmd),
        .sts             (sts),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast)
    );
endmodule
`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for bmp_distinct_color_collector_top.
// Depends on bdc_pkg and the RTL; builds BMP byte streams and checks every
// output transfer against a built-in palette predictor.
`timescale 1ns / 1ps
module testbench;
    import bdc_pkg::*;

    localparam int SETTLE_CYCLES = 600;   // longest scan of a full palette plus margin
    localparam int WATCH_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_BYTES  = 1300;

    typedef enum int {
        F_NONE, F_SIG, F_DEPTH, F_LOW_OFS, F_WIDE, F_NEG_W, F_SHORT, F_SIG_DEPTH, F_DEPTH_GEOM
    } fault_t;

    typedef struct {
        bit         kind;
        bit [7:0]   idx;
        bit [7:0]   red;
        bit [7:0]   green;
        bit [7:0]   blue;
        bit [8:0]   count;
        bit [2:0]   status;
    } record_t;

    typedef struct {
        fault_t     fault;
        int         width;
        int         height;
        int         offset;
        int         limit;
        bit         cut;
        bit         pooled;
        bit [2:0]   status;
    } file_row_t;

    logic        clk;
    logic        rst_n;
    logic        color_cap_we;
    logic [8:0]  color_cap_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tlast;

    bmp_distinct_color_collector_top uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .color_cap_we    (color_cap_we),
        .color_cap_wdata (color_cap_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast)
    );

    // predictor state
    bit [8:0]   pm_color_cap;
    bit [31:0]  pm_pos;
    bit [31:0]  pm_offset;
    bit [31:0]  pm_width;
    bit [31:0]  pm_height;
    bit [15:0]  pm_bpp;
    bit [31:0]  pm_col;
    bit [31:0]  pm_rows;
    bit [15:0]  pm_partial;
    bit [23:0]  pm_palette [256];
    bit [8:0]   pm_found;
    bit [2:0]   pm_err;
    phase_t     pm_phase;
    bit [2:0]   last_status;

    record_t    expected_q[$];
    bit [7:0]   file_q[$];
    int         errors;
    int         bytes_sent;
    int         colors_seen;
    int         summaries_seen;
    int         files_sent;
    int         idle_count;
    bit         no_gaps;
    bit         hold_request;

    task automatic report(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic bit [31:0] limit_in_use();
        return (pm_color_cap > 9'd256) ? 32'd256 : 32'(pm_color_cap);
    endfunction

    function automatic bit [31:0] padded_row();
        return (pm_width * 3 + 3) & ~32'd3;
    endfunction

    function automatic bit [31:0] height_abs();
        return pm_height[31] ? (~pm_height + 1) : pm_height;
    endfunction

    function automatic void clear_file();
        pm_pos = 0; pm_offset = 0; pm_width = 0; pm_height = 0; pm_bpp = 0;
        pm_col = 0; pm_rows = 0; pm_partial = 0; pm_found = 0; pm_err = ST_OK;
        pm_phase = PH_HEADER;
    endfunction

    function automatic void start_pixels();
        if (padded_row() == 0 || height_abs() == 0 || pm_found >= limit_in_use())
            pm_phase = PH_DONE;
        else
            pm_phase = PH_PIXELS;
    endfunction

    function automatic void take_header(input bit [31:0] p, input bit [7:0] b);
        if (p == 0 && b != "B") pm_err = ST_BAD_SIG;
        if (p == 1 && b != "M") pm_err = ST_BAD_SIG;
        if (p >= 10 && p < 14) pm_offset |= 32'(b) << (8 * (p - 10));
        if (p >= 18 && p < 22) pm_width |= 32'(b) << (8 * (p - 18));
        if (p >= 22 && p < 26) pm_height |= 32'(b) << (8 * (p - 22));
        if (p >= 28 && p < 30) pm_bpp |= 16'(b) << (8 * (p - 28));
        if (p == HEADER_SIZE - 1)
        begin
            if (pm_err == ST_OK && pm_bpp != 16'd24) pm_err = ST_NOT_24;
            if (pm_err == ST_OK && (pm_offset < HEADER_SIZE || pm_width[31] ||
                                    pm_width > DEF_MAX_WIDTH))
                pm_err = ST_GEOM;
            if (pm_err != ST_OK) pm_phase = PH_ERROR;
            else if (pm_offset > HEADER_SIZE) pm_phase = PH_SKIP;
            else start_pixels();
        end
    endfunction

    function automatic void take_pixel(input bit [7:0] b);
        bit [23:0] rgb;
        bit        seen;
        record_t   r;
        if (pm_found >= limit_in_use())
        begin
            pm_phase = PH_DONE;
            return;
        end
        if (pm_col < pm_width * 3)
        begin
            case (pm_col % 3)
                0: pm_partial = {8'd0, b};
                1: pm_partial[15:8] = b;
                default:
                begin
                    rgb = {b, pm_partial};
                    seen = 0;
                    for (int i = 0; i < pm_found; i++)
                        if (pm_palette[i] == rgb) seen = 1;
                    if (!seen)
                    begin
                        pm_palette[pm_found] = rgb;
                        r = '{0, pm_found[7:0], rgb[23:16], rgb[15:8], rgb[7:0], 0, ST_OK};
                        expected_q.push_back(r);
                        pm_found++;
                    end
                end
            endcase
        end
        pm_col++;
        if (pm_col >= padded_row())
        begin
            pm_col = 0;
            pm_rows++;
            if (pm_rows >= height_abs()) pm_phase = PH_DONE;
        end
        if (pm_found >= limit_in_use()) pm_phase = PH_DONE;
    endfunction

    function automatic void predict_byte(input bit [7:0] b, input bit last);
        record_t   r;
        bit [2:0]  st;
        if (pm_phase == PH_HEADER) take_header(pm_pos, b);
        else if (pm_phase == PH_PIXELS) take_pixel(b);
        if (pm_pos != 32'hFFFF_FFFF) pm_pos++;
        if (pm_phase == PH_SKIP && pm_pos >= pm_offset) start_pixels();
        if (last)
        begin
            st = (pm_phase == PH_HEADER) ? ST_SHORT : pm_err;
            r = '{1, 0, 0, 0, 0, (st == ST_OK) ? pm_found : 9'd0, st};
            expected_q.push_back(r);
            last_status = st;
            clear_file();
        end
    endfunction

    always #10 clk = ~clk;

    // input monitor feeds the predictor
    always @(posedge clk)
        if (rst_n && s_tvalid && s_tready)
        begin
            predict_byte(s_tdata, s_tlast);
            bytes_sent++;
        end

    // output checker
    always @(posedge clk)
    begin
        record_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("MISMATCH unexpected output transfer %h at %0t", m_tdata, $realtime);
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (m_tlast != e.kind)            report("kind", m_tlast, e.kind);
                if (m_tdata[7:0] != e.idx)        report("color_index", m_tdata[7:0], e.idx);
                if (m_tdata[15:8] != e.red)       report("red", m_tdata[15:8], e.red);
                if (m_tdata[23:16] != e.green)    report("green", m_tdata[23:16], e.green);
                if (m_tdata[31:24] != e.blue)     report("blue", m_tdata[31:24], e.blue);
                if (m_tdata[40:32] != e.count)    report("color_count", m_tdata[40:32], e.count);
                if (m_tdata[43:41] != e.status)   report("status", m_tdata[43:41], e.status);
                if (m_tdata[47:44] != 4'd0)       report("tdata pad", m_tdata[47:44], 0);
                if (e.kind) summaries_seen++;
                else colors_seen++;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_count <= 0;
        else idle_count <= idle_count + 1;
        if (idle_count >= WATCH_LIMIT)
        begin
            $display("watchdog expired at %0t", $realtime);
            $display("bmp_distinct_color_collector_top test failed");
            $finish;
        end
    end

    // receiver with random stalls and one long hold-off
    initial
    begin
        int w;
        m_tready = 0;
        @(posedge rst_n);
        forever
        begin
            w = no_gaps ? 0 : $urandom_range(0, 17);
            if (hold_request)
            begin
                w = HOLD_CYCLES;
                hold_request = 0;
            end
            if (w > 0)
            begin
                m_tready <= 0;
                repeat (w) @(posedge clk);
            end
            m_tready <= 1;
            forever
            begin
                @(negedge clk);
                if (m_tvalid) break;
            end
            @(posedge clk);
        end
    end

    task automatic send_byte(input bit [7:0] b, input bit last);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            s_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata  <= b;
        s_tlast  <= last;
        forever
        begin
            @(negedge clk);
            if (s_tready) break;
        end
        @(posedge clk);
    endtask

    // idle pause, then a register write
    task automatic set_limit(input bit [8:0] v);
        s_tvalid <= 0;
        @(negedge clk);
        wait (expected_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        color_cap_we    <= 1;
        color_cap_wdata <= v;
        @(posedge clk);
        color_cap_we    <= 0;
        pm_color_cap = v;
    endtask

    function automatic void put32(input int p, input bit [31:0] v);
        for (int i = 0; i < 4; i++) file_q[p + i] = v[8 * i +: 8];
    endfunction

    task automatic build_file(input file_row_t f);
        bit [23:0] pool [4];
        bit [23:0] c;
        bit [31:0] ofs;
        int        rows;
        int        rowlen;
        int        len;
        file_q.delete();
        for (int i = 0; i < HEADER_SIZE; i++) file_q.push_back($urandom_range(0, 255));
        for (int i = 0; i < 4; i++) pool[i] = $urandom;
        ofs = f.offset;
        file_q[0] = "B";
        file_q[1] = "M";
        if (f.fault == F_SIG || f.fault == F_SIG_DEPTH) file_q[$urandom_range(0, 1)] ^= 8'h20;
        if (f.fault == F_LOW_OFS || f.fault == F_DEPTH_GEOM) ofs = $urandom_range(0, 53);
        put32(10, ofs);
        put32(18, (f.fault == F_WIDE) ? DEF_MAX_WIDTH + 1 :
                  (f.fault == F_NEG_W) ? -f.width - 1 : f.width);
        put32(22, f.height);
        file_q[28] = 8'd24;
        file_q[29] = 8'd0;
        if (f.fault == F_DEPTH || f.fault == F_SIG_DEPTH || f.fault == F_DEPTH_GEOM)
            file_q[28] = 8'd32;
        for (int i = HEADER_SIZE; i < int'(ofs); i++) file_q.push_back($urandom_range(0, 255));
        rows = (f.height == int'(32'h8000_0000)) ? 2 : (f.height < 0 ? -f.height : f.height);
        if (rows > 40) rows = 40;
        rowlen = (f.width * 3 + 3) & ~3;
        if (f.fault != F_NONE) rows = $urandom_range(0, 1);
        for (int r = 0; r < rows; r++)
            for (int x = 0; x < rowlen; x += 3)
            begin
                c = f.pooled ? pool[$urandom_range(0, 3)] : 24'($urandom);
                for (int k = 0; k < 3 && x + k < rowlen; k++)
                    file_q.push_back(x + k < f.width * 3 ? c[8 * k +: 8] : 8'($urandom));
            end
        if (!f.cut && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 5)) file_q.push_back($urandom_range(0, 255));
        if (f.fault == F_SHORT) len = $urandom_range(1, 53);
        else if (f.cut) len = $urandom_range(HEADER_SIZE, file_q.size());
        else len = file_q.size();
        while (file_q.size() > len) void'(file_q.pop_back());
    endtask

    task automatic send_file();
        for (int i = 0; i < file_q.size(); i++) send_byte(file_q[i], i == file_q.size() - 1);
        files_sent++;
    endtask

    file_row_t directed [] = '{
        '{F_NONE,       2,    2,  54, 256, 0, 0, ST_OK},
        '{F_SIG,        2,    2,  54, 256, 0, 0, ST_BAD_SIG},
        '{F_DEPTH,      2,    2,  54, 256, 0, 0, ST_NOT_24},
        '{F_LOW_OFS,    2,    2,  54, 256, 0, 0, ST_GEOM},
        '{F_WIDE,       2,    2,  54, 256, 0, 0, ST_GEOM},
        '{F_NEG_W,      2,    2,  54, 256, 0, 0, ST_GEOM},
        '{F_SHORT,      2,    2,  54, 256, 0, 0, ST_SHORT},
        '{F_SIG_DEPTH,  2,    2,  54, 256, 0, 0, ST_BAD_SIG},
        '{F_DEPTH_GEOM, 2,    2,  54, 256, 0, 0, ST_NOT_24},
        '{F_NONE,       0,    3,  54, 256, 0, 0, ST_OK},
        '{F_NONE,    8192,    0,  54, 256, 0, 0, ST_OK},
        '{F_NONE,       3,   -2,  60, 256, 0, 1, ST_OK},
        '{F_NONE,       1, int'(32'h8000_0000), 54, 256, 1, 0, ST_OK},
        '{F_NONE,       3,    3,  54,   1, 0, 0, ST_OK},
        '{F_NONE,       3,    3,  54,   0, 0, 0, ST_OK},
        '{F_NONE,       2,    3,  57, 511, 1, 1, ST_OK}
    };

    initial
    begin
        file_row_t f;
        clk = 0;
        rst_n = 0;
        color_cap_we = 0;
        color_cap_wdata = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tlast = 0;
        errors = 0;
        no_gaps = 0;
        hold_request = 0;
        pm_color_cap = COLOR_CAP_RESET;
        clear_file();
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // first file runs with the reset limit
        foreach (directed[i])
        begin
            if (i > 0) set_limit(directed[i].limit);
            build_file(directed[i]);
            send_file();
            s_tvalid <= 0;
            @(negedge clk);
            wait (expected_q.size() == 0);
            if (last_status != directed[i].status)
                report("directed status", last_status, directed[i].status);
        end

        // full palette: 256 distinct colors with the receiver held off once
        set_limit(256);
        f = '{F_NONE, 9, 30, 54, 256, 0, 0, ST_OK};
        build_file(f);
        hold_request = 1;
        send_file();

        while (bytes_sent < RANDOM_BYTES + 700)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                case ($urandom_range(0, 4))
                    0: set_limit(1);
                    1: set_limit(9'h1FF);
                    2: set_limit(0);
                    default: set_limit($urandom_range(1, 8));
                endcase
            end
            no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
            begin
                // noise: arbitrary bytes, sometimes starting with the first signature byte
                file_q.delete();
                repeat ($urandom_range(1, 70)) file_q.push_back($urandom_range(0, 255));
                if ($urandom_range(0, 1)) file_q[0] = "B";
                send_file();
            end
            else
            begin
                f.fault  = ($urandom_range(0, 9) == 0) ? fault_t'($urandom_range(1, 8)) : F_NONE;
                f.width  = $urandom_range(0, 5);
                f.height = int'($urandom_range(0, 8)) - 3;
                f.offset = ($urandom_range(0, 2) == 0) ? 54 + $urandom_range(1, 6) : 54;
                f.cut    = ($urandom_range(0, 4) == 0);
                f.pooled = ($urandom_range(0, 2) != 0);
                build_file(f);
                send_file();
            end
        end
        no_gaps = 0;
        s_tvalid <= 0;
        @(negedge clk);
        wait (expected_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_q.size() != 0)
            report("results still pending", expected_q.size(), 0);

        $display("covered %0d files, %0d bytes: %0d new colors and %0d summaries checked",
                 files_sent, bytes_sent, colors_seen, summaries_seen);
        if (errors == 0)
            $display("bmp_distinct_color_collector_top test passed");
        else
            $display("bmp_distinct_color_collector_top test failed");
        $finish;
    end
endmodule

>>> bmp_distinct_color_collector_top.f
+incdir+sv
sv/bdc_pkg.sv
sv/bdc_ctrl.sv
sv/bdc_datapath.sv
sv/bmp_distinct_color_collector_top.sv
verif/testbench.sv
